FILE: rtl/ctd_pkg.sv
`timescale 1ns / 1ps

package ctd_pkg;

  localparam logic [7:0] CharLf = 8'h0a;

  // Outcome of a size line when its newline arrives
  typedef struct packed {
    logic start_payload;
    logic terminate;
    logic overflow;
  } line_evt_t;

  typedef struct packed {
    logic        has_payload;
    logic [7:0]  payload_byte;
    logic        is_end;
    logic [31:0] total_length;
    logic        saw_terminator;
    logic        size_overflow;
  } res_t;

endpackage

FILE: rtl/ctd_if.sv
`timescale 1ns / 1ps

interface ctd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface ctd_out_if;
  logic        valid;
  logic        ready;
  logic        has_payload;
  logic [7:0]  payload_byte;
  logic        is_end;
  logic [31:0] total_length;
  logic        saw_terminator;
  logic        size_overflow;

  modport source (
    output valid, output has_payload, output payload_byte, output is_end,
    output total_length, output saw_terminator, output size_overflow, input ready
  );
  modport sink (
    input valid, input has_payload, input payload_byte, input is_end,
    input total_length, input saw_terminator, input size_overflow, output ready
  );
endinterface

FILE: rtl/ctd_size_parser.sv
`timescale 1ns / 1ps

module ctd_size_parser #(
  parameter int SIZE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  parse_en,
  input  logic                  line_end,
  input  logic                  clear,
  input  logic [7:0]            cur_byte,
  output ctd_pkg::line_evt_t    evt,
  output logic [SIZE_BITS-1:0]  size_val
);
  import ctd_pkg::*;

  localparam logic [2:0] PhWs     = 3'd0;
  localparam logic [2:0] PhSign   = 3'd1;
  localparam logic [2:0] PhDigits = 3'd2;
  localparam logic [2:0] PhZero   = 3'd3;
  localparam logic [2:0] PhPrefix = 3'd4;
  localparam logic [2:0] PhDone   = 3'd5;
  localparam logic [2:0] PhOvf    = 3'd6;
  localparam logic [2:0] PhFail   = 3'd7;

  logic [2:0]           phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] accum_r, accum_nxt;
  logic                 neg_r, neg_nxt;
  logic                 digit_r, digit_nxt;

  logic       is_hex;
  logic [3:0] hex_val;
  logic       is_ws;
  logic       is_sign;
  logic       acc_full;
  logic       take;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (cur_byte >= 8'h30 && cur_byte <= 8'h39) begin
      hex_val = 4'(cur_byte - 8'h30);
    end else if (cur_byte >= 8'h61 && cur_byte <= 8'h66) begin
      hex_val = 4'(cur_byte - 8'h57);
    end else if (cur_byte >= 8'h41 && cur_byte <= 8'h46) begin
      hex_val = 4'(cur_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_ws = (cur_byte == 8'h20) || (cur_byte == 8'h09) || (cur_byte == 8'h0b) ||
                 (cur_byte == 8'h0c) || (cur_byte == 8'h0d);
  assign is_sign  = (cur_byte == 8'h2b) || (cur_byte == 8'h2d);
  assign acc_full = |accum_r[SIZE_BITS-1 -: 4];

  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    neg_nxt   = neg_r;
    digit_nxt = digit_r;
    if (clear || line_end) begin
      phase_nxt = PhWs;
      accum_nxt = '0;
      neg_nxt   = 1'b0;
      digit_nxt = 1'b0;
    end else if (parse_en) begin
      case (phase_r)
        PhWs, PhSign: begin
          if (phase_r == PhWs && is_ws) begin
            phase_nxt = phase_r;
          end else if (phase_r == PhWs && is_sign) begin
            neg_nxt   = (cur_byte == 8'h2d);
            phase_nxt = PhSign;
          end else if (cur_byte == 8'h30) begin
            digit_nxt = 1'b1;
            phase_nxt = PhZero;
          end else if (is_hex) begin
            if (acc_full) begin
              phase_nxt = PhOvf;
            end else begin
              phase_nxt = PhDigits;
              accum_nxt = {accum_r[SIZE_BITS-5:0], hex_val};
              digit_nxt = 1'b1;
            end
          end else begin
            phase_nxt = PhFail;
          end
        end
        PhZero, PhPrefix, PhDigits: begin
          if (phase_r == PhZero && (cur_byte == 8'h78 || cur_byte == 8'h58)) begin
            phase_nxt = PhPrefix;
          end else if (is_hex) begin
            if (acc_full) begin
              phase_nxt = PhOvf;
            end else begin
              phase_nxt = PhDigits;
              accum_nxt = {accum_r[SIZE_BITS-5:0], hex_val};
              digit_nxt = 1'b1;
            end
          end else begin
            phase_nxt = PhDone;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PhWs;
      accum_r <= '0;
      neg_r   <= 1'b0;
      digit_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      neg_r   <= neg_nxt;
      digit_r <= digit_nxt;
    end
  end

  assign take               = digit_r && (phase_r != PhFail) && (phase_r != PhOvf);
  assign evt.overflow       = (phase_r == PhOvf);
  assign evt.terminate      = take && (accum_r == '0);
  assign evt.start_payload  = take && (accum_r != '0) && !neg_r;
  assign size_val           = accum_r;

`ifndef SYNTHESIS
  // overflow is only reached when a new digit would shift a nonzero top nibble out
  a_ovf_after_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PhOvf) |-> (digit_r && acc_full))
    else $error("overflow phase without a full accumulator");
`endif

endmodule

FILE: rtl/ctd_out_stage.sv
`timescale 1ns / 1ps

module ctd_out_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  ctd_pkg::res_t   push_data,
  output logic            push_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output ctd_pkg::res_t   out_data
);
  import ctd_pkg::*;

  logic  out_valid_r, out_valid_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  res_t  out_data_r, out_data_nxt;
  res_t  skid_data_r, skid_data_nxt;

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push_valid;
        out_data_nxt  = push_data;
      end
    end else if (push_valid) begin
      // hold the new word while the output is stalled
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");
  a_stalled_out_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && out_data_r == $past(out_data_r)))
    else $error("stalled output word changed");
`endif

endmodule

FILE: rtl/chunked_transfer_decoder.sv
`timescale 1ns / 1ps

// Chunked body decoder.
// in_ch carries one body byte per word plus buffer_end on the buffer's last
// byte. out_ch carries a word for every payload byte and one for the last
// byte of each buffer; the last word has is_end set with the payload count,
// terminator and overflow status. Bytes of size lines, CRLF and everything
// after the zero-size line produce no word.
// Throughput: one input word per cycle while in_ch.ready is high. The line state and payload counter
// update in the accept cycle, so there is no dependency stall.
// A result is held in the output register before it appears on out_ch.
// Stall: an output register plus a skid register part the channels; with
// the receiver stalled, one more result word goes into the skid register,
// then in_ch.ready drops until the receiver takes a word. Bytes that give
// no result keep flowing until the skid register fills.
// Reset (rst_n low, synchronous): all decode state clears, both output
// registers empty. After the last byte of a buffer the decoder returns to
// its reset state on its own.
module chunked_transfer_decoder #(
  parameter int SIZE_BITS   = 32,
  parameter int LENGTH_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  ctd_in_if.sink   in_ch,
  ctd_out_if.source out_ch
);
  import ctd_pkg::*;

  localparam int WideBits = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  logic                   accept;
  logic                   push_ready;
  logic                   active;
  logic                   is_lf;
  logic                   emit;
  logic                   last;
  line_evt_t              evt;
  logic [SIZE_BITS-1:0]   size_val;

  logic [SIZE_BITS-1:0]   remain_r, remain_nxt;
  logic                   in_payload_r, in_payload_nxt;
  logic                   terminated_r, terminated_nxt;
  logic [LENGTH_BITS-1:0] written_r, written_nxt;
  logic                   overflow_r, overflow_nxt;
  logic [WideBits-1:0]    written_wide;
  logic [SIZE_BITS-1:0]   remain_dec;
  res_t                   res;
  res_t                   out_data;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign last        = in_ch.buffer_end;
  assign is_lf       = (in_ch.in_byte == CharLf);
  assign active      = accept && !terminated_r && !in_payload_r;
  assign emit        = accept && !terminated_r && in_payload_r;
  assign remain_dec  = remain_r - SIZE_BITS'(1);

  ctd_size_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .parse_en (active && !is_lf),
    .line_end (active && is_lf),
    .clear    (accept && last),
    .cur_byte (in_ch.in_byte),
    .evt      (evt),
    .size_val (size_val)
  );

  always_comb begin
    remain_nxt     = remain_r;
    in_payload_nxt = in_payload_r;
    terminated_nxt = terminated_r;
    written_nxt    = written_r;
    overflow_nxt   = overflow_r;
    if (emit) begin
      if (written_r != '1) begin
        written_nxt = written_r + LENGTH_BITS'(1);
      end
      remain_nxt = remain_dec;
      if (remain_dec == '0) begin
        in_payload_nxt = 1'b0;
      end
    end else if (active && is_lf) begin
      if (evt.overflow) begin
        overflow_nxt = 1'b1;
      end else if (evt.terminate) begin
        terminated_nxt = 1'b1;
      end else if (evt.start_payload) begin
        remain_nxt     = size_val;
        in_payload_nxt = 1'b1;
      end
    end
  end

  // saturate the running count into the 32-bit report
  assign written_wide = WideBits'(written_nxt);

  always_comb begin
    res.has_payload    = emit;
    res.payload_byte   = emit ? in_ch.in_byte : 8'd0;
    res.is_end         = last;
    res.total_length   = 32'd0;
    res.saw_terminator = last && terminated_nxt;
    res.size_overflow  = last && overflow_nxt;
    if (last) begin
      if (written_wide > WideBits'(32'hffff_ffff)) begin
        res.total_length = 32'hffff_ffff;
      end else begin
        res.total_length = written_wide[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last)) begin
      remain_r     <= '0;
      in_payload_r <= 1'b0;
      terminated_r <= 1'b0;
      written_r    <= '0;
      overflow_r   <= 1'b0;
    end else begin
      remain_r     <= remain_nxt;
      in_payload_r <= in_payload_nxt;
      terminated_r <= terminated_nxt;
      written_r    <= written_nxt;
      overflow_r   <= overflow_nxt;
    end
  end

  ctd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (emit || (accept && last)),
    .push_data  (res),
    .push_ready (push_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_data)
  );

  assign out_ch.has_payload    = out_data.has_payload;
  assign out_ch.payload_byte   = out_data.payload_byte;
  assign out_ch.is_end         = out_data.is_end;
  assign out_ch.total_length   = out_data.total_length;
  assign out_ch.saw_terminator = out_data.saw_terminator;
  assign out_ch.size_overflow  = out_data.size_overflow;

`ifndef SYNTHESIS
  a_term_excl_payload: assert property (@(posedge clk) disable iff (!rst_n)
    !(terminated_r && in_payload_r))
    else $error("payload active after terminator");
  a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> (remain_r != '0))
    else $error("payload active with nothing remaining");
  a_buffer_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (!in_payload_r && !terminated_r && !overflow_r &&
                          written_r == '0))
    else $error("state not cleared after buffer end");
`endif

endmodule

FILE: dv/chunked_transfer_decoder_tb.sv
`timescale 1ns / 1ps

module chunked_transfer_decoder_tb;
  import ctd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_BYTES   = 560;
  localparam int TAIL_BYTES     = 200;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0b;
  localparam logic [7:0] CH_FF  = 8'h0c;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [31:0] SIZE_LIMIT   = 32'hffff_ffff;
  localparam logic [31:0] LENGTH_LIMIT = 32'hffff_ffff;

  typedef enum logic [2:0] {
    SCAN_BLANK, SCAN_SIGN, SCAN_DIGITS, SCAN_ZERO,
    SCAN_PREFIX, SCAN_DONE, SCAN_OVERFLOW, SCAN_FAIL
  } scan_phase_e;

  logic clk = 1'b0;
  logic rst_n;

  ctd_in_if  in_ch ();
  ctd_out_if out_ch ();

  chunked_transfer_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // decoder state as predicted
  scan_phase_e scan_phase;
  logic [31:0] size_value;
  logic        size_minus;
  logic        have_digit;
  logic [31:0] chunk_left;
  logic        in_chunk;
  logic        done_seen;
  logic [31:0] payload_count;
  logic        ovf_flag;

  res_t pending_words[$];
  logic [7:0] body[$];
  logic [7:0] blanks [5] = '{CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR};

  int   mismatch_count = 0;
  int   stall_cycles = 0;
  int   bytes_sent = 0;
  int   hold_count;
  bit   idle_on;
  bit   long_hold_req;

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic void clear_line();
    scan_phase = SCAN_BLANK;
    size_value = '0;
    size_minus = 1'b0;
    have_digit = 1'b0;
  endfunction

  function automatic void clear_decoder();
    clear_line();
    chunk_left    = '0;
    in_chunk      = 1'b0;
    done_seen     = 1'b0;
    payload_count = '0;
    ovf_flag      = 1'b0;
  endfunction

  function automatic void push_digit(int d);
    if (size_value > (SIZE_LIMIT >> 4)) begin
      scan_phase = SCAN_OVERFLOW;
    end else begin
      size_value = (size_value << 4) | 32'(d);
      have_digit = 1'b1;
    end
  endfunction

  function automatic void finish_line();
    if (scan_phase == SCAN_OVERFLOW) begin
      ovf_flag = 1'b1;
    end else if (have_digit && scan_phase != SCAN_FAIL) begin
      if (size_value == 0) begin
        done_seen = 1'b1;
      end else if (!size_minus) begin
        chunk_left = size_value;
        in_chunk   = 1'b1;
      end
    end
    clear_line();
  endfunction

  function automatic void scan_char(logic [7:0] c);
    int d;
    d = hex_digit(c);
    case (scan_phase)
      SCAN_BLANK, SCAN_SIGN: begin
        if (scan_phase == SCAN_BLANK && (c == "+" || c == "-")) begin
          size_minus = (c == "-");
          scan_phase = SCAN_SIGN;
        end else if (!(scan_phase == SCAN_BLANK && is_blank(c))) begin
          if (c == "0") begin
            have_digit = 1'b1;
            scan_phase = SCAN_ZERO;
          end else if (d >= 0) begin
            scan_phase = SCAN_DIGITS;
            push_digit(d);
          end else begin
            scan_phase = SCAN_FAIL;
          end
        end
      end
      SCAN_ZERO: begin
        if (c == "x" || c == "X") scan_phase = SCAN_PREFIX;
        else if (d >= 0) begin
          scan_phase = SCAN_DIGITS;
          push_digit(d);
        end else scan_phase = SCAN_DONE;
      end
      SCAN_PREFIX, SCAN_DIGITS: begin
        if (d >= 0) begin
          scan_phase = SCAN_DIGITS;
          push_digit(d);
        end else scan_phase = SCAN_DONE;
      end
      default: ;
    endcase
  endfunction

  // advance the predicted decoder by one accepted byte
  function automatic void decode_byte(logic [7:0] c, logic last);
    bit   emit;
    res_t w;
    emit = 1'b0;
    if (!done_seen) begin
      if (in_chunk) begin
        emit = 1'b1;
        if (payload_count < LENGTH_LIMIT) payload_count++;
        chunk_left = chunk_left - 1;
        if (chunk_left == 0) in_chunk = 1'b0;
      end else if (c == CharLf) begin
        finish_line();
      end else begin
        scan_char(c);
      end
    end
    if (emit || last) begin
      w = '0;
      w.has_payload  = emit;
      w.payload_byte = emit ? c : 8'h00;
      w.is_end       = last;
      if (last) begin
        w.total_length   = payload_count;
        w.saw_terminator = done_seen;
        w.size_overflow  = ovf_flag;
      end
      pending_words.push_back(w);
    end
    if (last) clear_decoder();
  endfunction

  function automatic string word_text(res_t w);
    return $sformatf("pay=%0b byte=%02h end=%0b len=%0d term=%0b ovf=%0b",
                     w.has_payload, w.payload_byte, w.is_end, w.total_length,
                     w.saw_terminator, w.size_overflow);
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    bit   bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.has_payload    = out_ch.has_payload;
      got.payload_byte   = out_ch.payload_byte;
      got.is_end         = out_ch.is_end;
      got.total_length   = out_ch.total_length;
      got.saw_terminator = out_ch.saw_terminator;
      got.size_overflow  = out_ch.size_overflow;
      if (pending_words.size() == 0) begin
        want = '0;
        bad  = 1'b1;
        if (mismatch_count < 10) $display("unexpected word: %s", word_text(got));
      end else begin
        want = pending_words.pop_front();
        bad = (got.has_payload !== want.has_payload) ||
              (got.payload_byte !== want.payload_byte) ||
              (got.is_end !== want.is_end) ||
              (got.total_length !== want.total_length) ||
              (got.saw_terminator !== want.saw_terminator) ||
              (got.size_overflow !== want.size_overflow);
        if (bad && mismatch_count < 10)
          $display("mismatch at %0t: expected %s, actual %s", $time,
                   word_text(want), word_text(got));
      end
      if (bad) mismatch_count++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result receiver: random stalls, plus one long hold on request
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ch.ready = 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(negedge clk);
        out_ch.ready = 1'b1;
        long_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_ch.ready = 1'b1;
      end
    end
  end

  // call at a falling edge; returns at the falling edge after the accept
  task automatic send_byte(logic [7:0] c, logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.in_byte    = c;
    in_ch.buffer_end = last;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(c, last);
    bytes_sent++;
    @(negedge clk);
    // drop the word unless the next call offers another at once
    in_ch.valid = 1'b0;
  endtask

  task automatic send_body();
    for (int i = 0; i < body.size(); i++) send_byte(body[i], i == body.size() - 1);
  endtask

  task automatic wait_results_drained();
    in_ch.valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic void add_char(logic [7:0] c);
    body.push_back(c);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
  endfunction

  function automatic void add_crlf();
    if ($urandom_range(0, 4) != 0) add_char(CH_CR);
    add_char(CharLf);
  endfunction

  function automatic void add_size_line(logic [31:0] sz);
    string digits;
    int    pick;
    repeat ($urandom_range(0, 2)) add_char(blanks[$urandom_range(0, 4)]);
    if ($urandom_range(0, 7) == 0) add_text("+");
    if ($urandom_range(0, 5) == 0) add_text($urandom_range(0, 1) ? "0x" : "0X");
    if ($urandom_range(0, 4) == 0) add_text("00");
    digits = $sformatf("%0h", sz);
    if ($urandom_range(0, 1)) digits = digits.toupper();
    add_text(digits);
    pick = $urandom_range(0, 5);
    if (pick == 0) add_text(";ext=1");
    else if (pick == 1) add_char(CH_SP);
    add_crlf();
  endfunction

  // chunked body with random content, sometimes with bad or oversized size lines, sometimes cut short
  function automatic void make_chunked_body();
    int unsigned n_chunks;
    int unsigned cut;
    logic [31:0] sz;
    body.delete();
    n_chunks = $urandom_range(1, 4);
    for (int k = 0; k < n_chunks; k++) begin
      case ($urandom_range(0, 19))
        0: begin add_text("-5"); add_crlf(); end
        1: begin add_text("zz"); add_crlf(); end
        2: begin add_text($sformatf("1%08h", $urandom)); add_crlf(); end
        default: ;
      endcase
      if ($urandom_range(0, 39) == 0) begin
        // huge size: the buffer ends inside the payload
        add_size_line($urandom | 32'h100);
        repeat ($urandom_range(0, 20)) add_char(8'($urandom));
        return;
      end
      sz = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 120) : $urandom_range(1, 16);
      add_size_line(sz);
      repeat (sz) add_char(8'($urandom));
      add_crlf();
    end
    add_size_line(32'h0);
    if ($urandom_range(0, 1)) add_crlf();
    if ($urandom_range(0, 9) == 0) begin
      add_text("7");
      add_char(CharLf);
      add_char(8'($urandom));
    end
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, body.size());
      while (body.size() > cut) void'(body.pop_back());
    end
  endfunction

  function automatic void make_noise_body();
    string alphabet;
    alphabet = "0123456789abcdefABCDEFxX+-;g ";
    body.delete();
    repeat ($urandom_range(1, 24)) begin
      case ($urandom_range(0, 3))
        0: add_char(8'($urandom));
        1: add_char(($urandom_range(0, 1)) ? CharLf : blanks[$urandom_range(0, 4)]);
        default: add_char(alphabet[$urandom_range(0, alphabet.len() - 1)]);
      endcase
    end
  endfunction

  task automatic send_random_bodies(int goal);
    goal = bytes_sent + goal;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 4) == 0) make_noise_body();
      else make_chunked_body();
      send_body();
    end
  endtask

  // negative size skipped, 0X prefix, zero byte ends the number, short payload
  task automatic test_payload_prefix();
    body.delete();
    add_text("-3");
    add_char(CharLf);
    add_text("0X3");
    add_char(8'h00);
    add_char(CharLf);
    add_char(8'h00);
    add_char(8'hff);
    send_body();
  endtask

  // leading blanks skipped, minus zero terminates, later bytes dropped
  task automatic test_blank_terminator();
    body.delete();
    add_char(CH_TAB);
    add_char(CH_VT);
    add_char(CH_FF);
    add_char(CH_CR);
    add_text("-0");
    add_char(CharLf);
    add_text("Z");
    send_body();
  endtask

  task automatic test_bare_prefix();
    body.delete();
    add_text("0x");
    add_char(CharLf);
    add_text("7");
    send_body();
  endtask

  // line without a number, then a size line cut by the buffer end
  task automatic test_unparsed_lines();
    body.delete();
    add_text("g");
    add_char(CharLf);
    add_text("5");
    send_body();
  endtask

  task automatic test_size_overflow();
    body.delete();
    add_text("100000000");
    add_char(CharLf);
    add_text("+");
    send_body();
  endtask

  task automatic test_random_bodies();
    send_random_bodies(RANDOM_BYTES);
  endtask

  // keep offering while the receiver holds off, so the input stalls
  task automatic test_receiver_hold();
    long_hold_req = 1'b1;
    body.delete();
    add_text("40");
    add_char(CH_CR);
    add_char(CharLf);
    repeat (64) add_char(8'($urandom));
    add_char(CH_CR);
    add_char(CharLf);
    add_text("0");
    add_char(CharLf);
    send_body();
    while (long_hold_req) @(negedge clk);
  endtask

  task automatic test_sender_drain();
    make_chunked_body();
    send_body();
    wait_results_drained();
    send_random_bodies(100);
  endtask

  task automatic test_back_to_back();
    send_random_bodies(TAIL_BYTES);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = 8'h00;
    in_ch.buffer_end = 1'b0;
    idle_on          = 1'b0;
    long_hold_req    = 1'b0;
    clear_decoder();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_payload_prefix();
    test_blank_terminator();
    test_bare_prefix();
    test_unparsed_lines();
    test_size_overflow();

    idle_on = 1'b1;
    test_random_bodies();
    test_receiver_hold();
    test_sender_drain();

    idle_on = 1'b0;
    test_back_to_back();

    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ctd_pkg.sv
rtl/ctd_if.sv
rtl/ctd_size_parser.sv
rtl/ctd_out_stage.sv
rtl/chunked_transfer_decoder.sv
dv/chunked_transfer_decoder_tb.sv
